// ===== hw/rtl/i2crs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crs_pkg
// Types and constants shared by the I2C register slave with host keepalive.
// ----------------------------------------------------------------------------
package i2crs_pkg;

   typedef enum logic [1:0] {
      OP_RX     = 2'd0,
      OP_READ   = 2'd1,
      OP_FINISH = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_SERIAL_NUM    = 2'd0,
      CSR_HW_VERSION    = 2'd1,
      CSR_SW_VERSION    = 2'd2,
      CSR_ALIVE_TIMEOUT = 2'd3
   } csr_index_type;

   localparam logic [7:0] ADDR_HW_ID_HI    = 8'h08;
   localparam logic [7:0] ADDR_HW_ID_LO    = 8'h09;
   localparam logic [7:0] ADDR_SW_ID_HI    = 8'h0A;
   localparam logic [7:0] ADDR_SW_ID_LO    = 8'h0B;
   localparam logic [7:0] ADDR_RING_MODE   = 8'h12;
   localparam logic [7:0] ADDR_IR_BRIGHT   = 8'h20;
   localparam logic [7:0] ADDR_RING_BRIGHT = 8'h21;
   localparam logic [7:0] ADDR_TEMP_HI     = 8'h31;
   localparam logic [7:0] ADDR_TEMP_LO     = 8'h32;
   localparam logic [7:0] ADDR_ALIVE       = 8'hA0;

   localparam logic [7:0] EFFECT_BOOTING      = 8'd1;
   localparam logic [7:0] EFFECT_OKAY         = 8'd3;
   localparam logic [7:0] EFFECT_DISCONNECTED = 8'd4;

   localparam logic [7:0]  RING_LEVEL_RESET    = 8'd5;
   localparam logic [15:0] HW_VERSION_RESET    = 16'hFFFF;
   localparam logic [15:0] SW_VERSION_RESET    = 16'hFFFE;
   localparam logic [15:0] ALIVE_TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] IDLE_TICKS_MAX      = 16'hFFFF;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  rx_byte;
      logic [11:0] temp_sample;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic [7:0] ir_level;
      logic [7:0] ring_level;
      logic [7:0] ring_effect;
      logic       connected;
   } rsp_type;

   typedef struct packed {
      logic tick;
      logic alive;
   } ka_ctrl_type;

   typedef struct packed {
      logic link_next;
      logic set_okay;
      logic set_disc;
   } ka_status_type;

endpackage

// ===== hw/rtl/i2crs_keepalive.sv =====
// ----------------------------------------------------------------------------
// i2crs_keepalive
// Host keepalive monitor: saturating idle tick counter and link status.
// ----------------------------------------------------------------------------
module i2crs_keepalive import i2crs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ka_ctrl_type   ctrl,
   input  logic [15:0]   timeout,
   output ka_status_type status
);

   logic        link_up_ff, link_up_in;
   logic        ever_alive_ff, ever_alive_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;
   logic        come_up, go_down;

   always_comb begin
      come_up = ctrl.tick && (idle_ticks_ff < timeout) && !link_up_ff && ever_alive_ff;
      go_down = ctrl.tick && !come_up && (idle_ticks_ff > timeout) && link_up_ff;

      link_up_in = link_up_ff;
      if (come_up) begin
         link_up_in = 1'b1;
      end else if (go_down) begin
         link_up_in = 1'b0;
      end

      ever_alive_in = ever_alive_ff | ctrl.alive;

      idle_ticks_in = idle_ticks_ff;
      if (ctrl.alive) begin
         idle_ticks_in = '0;
      end else if (ctrl.tick && (idle_ticks_ff != IDLE_TICKS_MAX)) begin
         idle_ticks_in = idle_ticks_ff + 16'd1;
      end

      status.link_next = link_up_in;
      status.set_okay  = come_up;
      status.set_disc  = go_down;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff    <= 1'b0;
         ever_alive_ff <= 1'b0;
         idle_ticks_ff <= '0;
      end else begin
         link_up_ff    <= link_up_in;
         ever_alive_ff <= ever_alive_in;
         idle_ticks_ff <= idle_ticks_in;
      end
   end

endmodule

// ===== hw/rtl/i2c_register_slave_with_keepalive.sv =====
// ----------------------------------------------------------------------------
// i2c_register_slave_with_keepalive
// Register side of an I2C slave with staged LED settings and host keepalive.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  req     | req_valid, req_stall, req_data | one event/tick a cycle unstalled
//  rsp     | rsp_valid, rsp_stall, rsp_data | one result item per req item
//  csr     | csr_valid, csr_ready, csr_*    | configuration register write
//
//  Each item updates the register state in the cycle it is accepted and its
//  result appears in the output register on the next cycle: one item per
//  cycle while no result is held by rsp_stall. req_stall is raised only
//  while a result is held by rsp_stall. Synchronous reset restores all
//  state but the rsp_data register; csr_ready is always high.
// ----------------------------------------------------------------------------
module i2c_register_slave_with_keepalive import i2crs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [63:0]   csr_data
);

   logic [63:0] serial_ff;
   logic [15:0] hw_version_ff;
   logic [15:0] sw_version_ff;
   logic [15:0] alive_timeout_ff;

   logic [7:0] pointer_ff, pointer_in;
   logic       write_phase_ff, write_phase_in;
   logic [7:0] staged_ir_ff, staged_ir_in;
   logic [7:0] staged_ring_ff, staged_ring_in;
   logic [7:0] staged_effect_ff, staged_effect_in;
   logic [7:0] live_ir_ff, live_ir_in;
   logic [7:0] live_ring_ff, live_ring_in;
   logic [7:0] live_effect_ff, live_effect_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic          req_fire;
   logic [7:0]    read_byte;
   ka_ctrl_type   ka_ctrl;
   ka_status_type ka_status;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ka_ctrl.tick  = req_fire && (req_data.opcode == OP_TICK);
   assign ka_ctrl.alive = req_fire && (req_data.opcode == OP_RX) && write_phase_ff
                          && (pointer_ff == ADDR_ALIVE);

   i2crs_keepalive u_keepalive (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ka_ctrl),
      .timeout (alive_timeout_ff),
      .status  (ka_status)
   );

   always_comb begin
      read_byte = '0;
      if (pointer_ff[7:3] == 5'd0) begin
         read_byte = serial_ff[{pointer_ff[2:0], 3'b000} +: 8];
      end else begin
         case (pointer_ff)
            ADDR_HW_ID_HI:    read_byte = hw_version_ff[15:8];
            ADDR_HW_ID_LO:    read_byte = hw_version_ff[7:0];
            ADDR_SW_ID_HI:    read_byte = sw_version_ff[15:8];
            ADDR_SW_ID_LO:    read_byte = sw_version_ff[7:0];
            ADDR_RING_MODE:   read_byte = live_effect_ff;
            ADDR_IR_BRIGHT:   read_byte = live_ir_ff;
            ADDR_RING_BRIGHT: read_byte = live_ring_ff;
            ADDR_TEMP_HI:     read_byte = {4'd0, req_data.temp_sample[11:8]};
            ADDR_TEMP_LO:     read_byte = req_data.temp_sample[7:0];
            default:          read_byte = '0;
         endcase
      end
   end

   always_comb begin
      pointer_in       = pointer_ff;
      write_phase_in   = write_phase_ff;
      staged_ir_in     = staged_ir_ff;
      staged_ring_in   = staged_ring_ff;
      staged_effect_in = staged_effect_ff;
      live_ir_in       = live_ir_ff;
      live_ring_in     = live_ring_ff;
      live_effect_in   = live_effect_ff;
      rsp_in           = rsp_ff;

      if (req_fire) begin
         rsp_in.tx_byte = '0;
         case (req_data.opcode)
            OP_RX: begin
               if (!write_phase_ff) begin
                  pointer_in     = req_data.rx_byte;
                  write_phase_in = 1'b1;
               end else begin
                  case (pointer_ff)
                     ADDR_IR_BRIGHT:   staged_ir_in     = req_data.rx_byte;
                     ADDR_RING_BRIGHT: staged_ring_in   = req_data.rx_byte;
                     ADDR_RING_MODE:   staged_effect_in = req_data.rx_byte;
                     default:          ;
                  endcase
               end
            end
            OP_READ: begin
               rsp_in.tx_byte = read_byte;
               pointer_in     = pointer_ff + 8'd1;
            end
            OP_FINISH: begin
               write_phase_in = 1'b0;
            end
            OP_TICK: begin
               if (ka_status.set_okay) begin
                  staged_effect_in = EFFECT_OKAY;
               end else if (ka_status.set_disc) begin
                  staged_effect_in = EFFECT_DISCONNECTED;
               end
               live_ir_in     = staged_ir_ff;
               live_ring_in   = staged_ring_ff;
               live_effect_in = staged_effect_in;
            end
            default: ;
         endcase
         rsp_in.ir_level    = live_ir_in;
         rsp_in.ring_level  = live_ring_in;
         rsp_in.ring_effect = live_effect_in;
         rsp_in.connected   = ka_status.link_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff        <= '0;
         hw_version_ff    <= HW_VERSION_RESET;
         sw_version_ff    <= SW_VERSION_RESET;
         alive_timeout_ff <= ALIVE_TIMEOUT_RESET;
         pointer_ff       <= '0;
         write_phase_ff   <= 1'b0;
         staged_ir_ff     <= '0;
         staged_ring_ff   <= RING_LEVEL_RESET;
         staged_effect_ff <= EFFECT_BOOTING;
         live_ir_ff       <= '0;
         live_ring_ff     <= '0;
         live_effect_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SERIAL_NUM:    serial_ff        <= csr_data;
               CSR_HW_VERSION:    hw_version_ff    <= csr_data[15:0];
               CSR_SW_VERSION:    sw_version_ff    <= csr_data[15:0];
               CSR_ALIVE_TIMEOUT: alive_timeout_ff <= csr_data[15:0];
               default:           ;
            endcase
         end
         pointer_ff       <= pointer_in;
         write_phase_ff   <= write_phase_in;
         staged_ir_ff     <= staged_ir_in;
         staged_ring_ff   <= staged_ring_in;
         staged_effect_ff <= staged_effect_in;
         live_ir_ff       <= live_ir_in;
         live_ring_ff     <= live_ring_in;
         live_effect_ff   <= live_effect_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== bench/i2c_register_slave_with_keepalive_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_register_slave_with_keepalive_tb
// Self-checking bench for the I2C register slave with host keepalive. Bus
// events and ticks are driven through the request channel with random gaps,
// results are taken with random stalls, and every result is compared field
// by field against a mirror of the register file and link monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_slave_with_keepalive_tb;
   import i2crs_pkg::*;

   class reg_file_mirror;
      logic [63:0] serial_num;
      logic [15:0] hw_version;
      logic [15:0] sw_version;
      logic [15:0] alive_timeout;
      logic [7:0]  pointer;
      logic        writing;
      logic [7:0]  staged_ir;
      logic [7:0]  staged_ring;
      logic [7:0]  staged_effect;
      logic [7:0]  live_ir;
      logic [7:0]  live_ring;
      logic [7:0]  live_effect;
      logic        link_up;
      logic        ever_alive;
      logic [15:0] idle_ticks;
      rsp_type     awaited_rsp[$];
      int          failures;
      int          checked;
      int          link_changes;

      function void restart();
         serial_num    = '0;
         hw_version    = HW_VERSION_RESET;
         sw_version    = SW_VERSION_RESET;
         alive_timeout = ALIVE_TIMEOUT_RESET;
         pointer       = '0;
         writing       = 1'b0;
         staged_ir     = '0;
         staged_ring   = RING_LEVEL_RESET;
         staged_effect = EFFECT_BOOTING;
         live_ir       = '0;
         live_ring     = '0;
         live_effect   = '0;
         link_up       = 1'b0;
         ever_alive    = 1'b0;
         idle_ticks    = '0;
         awaited_rsp.delete();
      endfunction

      function void set_register(csr_index_type idx, logic [63:0] value);
         case (idx)
            CSR_SERIAL_NUM:    serial_num    = value;
            CSR_HW_VERSION:    hw_version    = value[15:0];
            CSR_SW_VERSION:    sw_version    = value[15:0];
            CSR_ALIVE_TIMEOUT: alive_timeout = value[15:0];
            default: ;
         endcase
      endfunction

      function void take_event(req_type item);
         rsp_type r;
         r = '0;
         case (item.opcode)
            OP_RX: begin
               if (!writing) begin
                  pointer = item.rx_byte;
                  writing = 1'b1;
               end else begin
                  case (pointer)
                     ADDR_IR_BRIGHT:   staged_ir     = item.rx_byte;
                     ADDR_RING_BRIGHT: staged_ring   = item.rx_byte;
                     ADDR_RING_MODE:   staged_effect = item.rx_byte;
                     ADDR_ALIVE: begin
                        ever_alive = 1'b1;
                        idle_ticks = '0;
                     end
                     default: ;
                  endcase
               end
            end
            OP_READ: begin
               if (pointer <= 8'h07) begin
                  r.tx_byte = serial_num[{pointer[2:0], 3'b000} +: 8];
               end else begin
                  case (pointer)
                     ADDR_HW_ID_HI:    r.tx_byte = hw_version[15:8];
                     ADDR_HW_ID_LO:    r.tx_byte = hw_version[7:0];
                     ADDR_SW_ID_HI:    r.tx_byte = sw_version[15:8];
                     ADDR_SW_ID_LO:    r.tx_byte = sw_version[7:0];
                     ADDR_RING_MODE:   r.tx_byte = live_effect;
                     ADDR_IR_BRIGHT:   r.tx_byte = live_ir;
                     ADDR_RING_BRIGHT: r.tx_byte = live_ring;
                     ADDR_TEMP_HI:     r.tx_byte = {4'h0, item.temp_sample[11:8]};
                     ADDR_TEMP_LO:     r.tx_byte = item.temp_sample[7:0];
                     default:          r.tx_byte = 8'h00;
                  endcase
               end
               pointer = pointer + 8'd1;
            end
            OP_FINISH: writing = 1'b0;
            default: begin
               if (idle_ticks < alive_timeout && !link_up && ever_alive) begin
                  link_up       = 1'b1;
                  staged_effect = EFFECT_OKAY;
                  link_changes++;
               end else if (idle_ticks > alive_timeout && link_up) begin
                  link_up       = 1'b0;
                  staged_effect = EFFECT_DISCONNECTED;
                  link_changes++;
               end
               if (idle_ticks != IDLE_TICKS_MAX) idle_ticks = idle_ticks + 16'd1;
               live_ir     = staged_ir;
               live_ring   = staged_ring;
               live_effect = staged_effect;
            end
         endcase
         r.ir_level    = live_ir;
         r.ring_level  = live_ring;
         r.ring_effect = live_effect;
         r.connected   = link_up;
         awaited_rsp.insert(awaited_rsp.size(), r);
      endfunction

      function void flag(string what, rsp_type want, rsp_type got);
         failures++;
         if (failures <= 10) begin
            $display("%0t mismatch:%s", $realtime, what);
            $display("   want tx=%h ir=%h ring=%h fx=%h link=%b", want.tx_byte,
                     want.ir_level, want.ring_level, want.ring_effect, want.connected);
            $display("   got  tx=%h ir=%h ring=%h fx=%h link=%b", got.tx_byte,
                     got.ir_level, got.ring_level, got.ring_effect, got.connected);
         end
      endfunction

      function void match_output(rsp_type got);
         rsp_type want;
         string   bad;
         checked++;
         if (awaited_rsp.size() == 0) begin
            flag(" result with nothing outstanding", '0, got);
            return;
         end
         want = awaited_rsp.pop_front();
         bad  = "";
         if (want.tx_byte !== got.tx_byte)         bad = {bad, " tx_byte"};
         if (want.ir_level !== got.ir_level)       bad = {bad, " ir_level"};
         if (want.ring_level !== got.ring_level)   bad = {bad, " ring_level"};
         if (want.ring_effect !== got.ring_effect) bad = {bad, " ring_effect"};
         if (want.connected !== got.connected)     bad = {bad, " connected"};
         if (bad != "") flag(bad, want, got);
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SERIAL_NUM;
   logic [63:0]   csr_data = '0;

   reg_file_mirror mirror;
   bit             calm = 1'b0;
   int             sent_items = 0;
   int             op_seen[4] = '{0, 0, 0, 0};
   int             phases = 0;

   i2c_register_slave_with_keepalive u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_pause();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic req_type make_req(opcode_type op, logic [7:0] b, logic [11:0] t);
      req_type r;
      r.opcode      = op;
      r.rx_byte     = b;
      r.temp_sample = t;
      return r;
   endfunction

   function automatic logic [7:0] pick_addr();
      int k;
      k = $urandom_range(0, 15);
      case (k)
         0:  return 8'($urandom_range(0, 7));
         1:  return ADDR_HW_ID_HI;
         2:  return ADDR_HW_ID_LO;
         3:  return ADDR_SW_ID_HI;
         4:  return ADDR_SW_ID_LO;
         5:  return ADDR_RING_MODE;
         6:  return ADDR_IR_BRIGHT;
         7:  return ADDR_RING_BRIGHT;
         8:  return ADDR_TEMP_HI;
         9:  return ADDR_TEMP_LO;
         10: return ADDR_ALIVE;
         11: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(req_type item);
      int gap;
      gap = draw_pause();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      mirror.take_event(item);
      sent_items++;
      op_seen[item.opcode]++;
   endtask

   task automatic send_op(opcode_type op, logic [7:0] b);
      send_item(make_req(op, b, 12'($urandom_range(0, 4095))));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (mirror.awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      mirror.set_register(idx, value);
   endtask

   task automatic run_random(int target);
      int start;
      int k;
      start = sent_items;
      while (sent_items - start < target) begin
         if ($urandom_range(0, 19) == 0) calm = !calm;
         k = $urandom_range(0, 99);
         if (k < 30) begin
            send_op(OP_RX, pick_addr());
            repeat ($urandom_range(1, 3)) send_op(OP_RX, 8'($urandom_range(0, 255)));
            send_op(OP_FINISH, 8'($urandom_range(0, 255)));
         end else if (k < 50) begin
            send_op(OP_RX, pick_addr());
            send_op(OP_FINISH, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4)) send_op(OP_READ, 8'($urandom_range(0, 255)));
         end else if (k < 62) begin
            send_op(OP_RX, ADDR_ALIVE);
            send_op(OP_RX, 8'($urandom_range(0, 255)));
            send_op(OP_FINISH, 8'($urandom_range(0, 255)));
         end else if (k < 85) begin
            repeat ($urandom_range(1, 6)) send_op(OP_TICK, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 3))
               send_op(opcode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         int gap;
         gap = draw_pause();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         mirror.match_output(rsp_data);
      end
   end

   initial begin
      int leftover;
      mirror = new();
      mirror.restart();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, then the corner cases
      send_item(make_req(OP_FINISH, 8'h00, 12'h000));
      send_item(make_req(OP_READ, 8'hFF, 12'hFFF));
      send_item(make_req(OP_TICK, 8'h00, 12'h000));
      send_item(make_req(OP_RX, ADDR_IR_BRIGHT, 12'hFFF));
      send_item(make_req(OP_RX, 8'hFF, 12'h000));
      send_item(make_req(OP_FINISH, 8'hFF, 12'hFFF));
      send_item(make_req(OP_RX, ADDR_RING_MODE, 12'h000));
      send_item(make_req(OP_RX, 8'hFF, 12'hFFF));
      send_item(make_req(OP_FINISH, 8'h00, 12'h000));
      send_item(make_req(OP_RX, ADDR_ALIVE, 12'hFFF));
      send_item(make_req(OP_RX, 8'h00, 12'h000));
      send_item(make_req(OP_FINISH, 8'h00, 12'hFFF));
      send_item(make_req(OP_TICK, 8'hFF, 12'h000));
      send_item(make_req(OP_RX, ADDR_HW_ID_HI, 12'hFFF));
      send_item(make_req(OP_FINISH, 8'h00, 12'h000));
      repeat (4) send_item(make_req(OP_READ, 8'h00, 12'hFFF));
      send_item(make_req(OP_RX, 8'hFF, 12'h000));
      send_item(make_req(OP_FINISH, 8'h00, 12'hFFF));
      send_item(make_req(OP_READ, 8'h00, 12'hFFF));
      send_item(make_req(OP_RX, ADDR_TEMP_HI, 12'h000));
      send_item(make_req(OP_FINISH, 8'h00, 12'h000));
      send_item(make_req(OP_READ, 8'h00, 12'hFFF));
      send_item(make_req(OP_READ, 8'hFF, 12'h0FF));

      for (int p = 0; p < 6; p++) begin
         logic [63:0] bid;
         logic [15:0] hw;
         logic [15:0] sw;
         logic [15:0] tmo;
         settle();
         case (p)
            0: begin
               bid = '0;
               hw  = '0;
               sw  = '0;
               tmo = 16'd1;
            end
            1: begin
               bid = '1;
               hw  = '1;
               sw  = '1;
               tmo = 16'hFFFF;
            end
            default: begin
               bid = {32'($urandom), 32'($urandom)};
               hw  = 16'($urandom_range(0, 65535));
               sw  = 16'($urandom_range(0, 65535));
               tmo = 16'($urandom_range(2, 12));
            end
         endcase
         write_csr(CSR_SERIAL_NUM, bid);
         write_csr(CSR_HW_VERSION, {48'h0, hw});
         write_csr(CSR_SW_VERSION, {48'h0, sw});
         write_csr(CSR_ALIVE_TIMEOUT, {48'h0, tmo});
         csr_valid <= 1'b0;
         phases++;
         run_random(320);
      end

      // bring the link up at the top timeout, then drop it with a zero timeout
      settle();
      write_csr(CSR_ALIVE_TIMEOUT, {48'h0, 16'hFFFF});
      csr_valid <= 1'b0;
      send_op(OP_FINISH, 8'h00);
      send_op(OP_RX, ADDR_ALIVE);
      send_op(OP_RX, 8'h5A);
      send_op(OP_FINISH, 8'h00);
      repeat (4) send_op(OP_TICK, 8'h00);
      settle();
      write_csr(CSR_ALIVE_TIMEOUT, {48'h0, 16'h0000});
      csr_valid <= 1'b0;
      phases++;
      repeat (3) send_op(OP_TICK, 8'h00);

      settle();
      repeat (4) @(posedge clock);
      leftover = mirror.awaited_rsp.size();
      $display("ran %0d items over %0d settings: %0d rx, %0d rd, %0d fin, %0d tick",
               sent_items, phases + 1, op_seen[OP_RX], op_seen[OP_READ],
               op_seen[OP_FINISH], op_seen[OP_TICK]);
      $display("checked %0d results, saw %0d link changes, %0d failures, %0d left over",
               mirror.checked, mirror.link_changes, mirror.failures, leftover);
      if (mirror.failures == 0 && leftover == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/i2crs_pkg.sv
hw/rtl/i2crs_keepalive.sv
hw/rtl/i2c_register_slave_with_keepalive.sv
bench/i2c_register_slave_with_keepalive_tb.sv
